>>> rtl/quadrature_position_pid_controller_macros.svh
// Assertion macros for the quadrature position PID controller.
// Expects clk and rst in the scope where the macros are used.
`ifndef QUADRATURE_POSITION_PID_CONTROLLER_MACROS_SVH
`define QUADRATURE_POSITION_PID_CONTROLLER_MACROS_SVH

// same-cycle implication
`define QPPC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qppc: same-cycle check failed");

// next-cycle implication
`define QPPC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qppc: next-cycle check failed");

`endif

>>> rtl/qppc_pkg.sv
// Shared types, codes and constants of the quadrature position PID controller.
// No dependencies.
package qppc_pkg;

  localparam int POS_W         = 32;
  localparam int SETTLE_STEPS  = 20;
  localparam int CNT_W         = 5;
  localparam int BAND          = 40;
  localparam int STEP_BACKOFF  = 250;
  localparam int SETTLE_BACKOFF = SETTLE_STEPS * STEP_BACKOFF;
  localparam int DRV_W         = 51;

  localparam logic signed [35:0] SAT_HI = 36'sd2147483647;
  localparam logic signed [35:0] SAT_LO = -36'sd2147483648;

  typedef enum logic [1:0] {
    DIR_FORWARD = 2'd0,
    DIR_BRAKE   = 2'd1,
    DIR_REVERSE = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    ST_NONE        = 2'd0,
    ST_LEVER_CLOSE = 2'd1,
    ST_FEED_START2 = 2'd2,
    ST_WAIT_INPUT  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_RETURN = 2'd0,
    PH_CLOSE  = 2'd1,
    PH_FEED   = 2'd2,
    PH_OTHER  = 2'd3
  } phase_t;

  typedef enum logic {
    FUNC_ENCODER = 1'b0,
    FUNC_CONTROL = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    REG_GAIN_CLOSE      = 3'd0,
    REG_GAIN_FEED       = 3'd1,
    REG_INTEGRAL_GAIN   = 3'd2,
    REG_DERIVATIVE_GAIN = 3'd3,
    REG_DRIVE_MIN       = 3'd4,
    REG_DRIVE_MAX       = 3'd5,
    REG_ENABLE          = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] gain_close;
    logic [15:0] gain_feed;
    logic [15:0] integral_gain;
    logic [15:0] derivative_gain;
    logic [15:0] drive_min;
    logic [15:0] drive_max;
    logic        enable;
  } cfg_t;

  typedef struct packed {
    func_t              func;
    logic               pin_a;
    logic               pin_b;
    logic signed [31:0] target_pos;
    phase_t             phase;
  } in_item_t;

  // after error / state stage
  typedef struct packed {
    logic               control;
    logic               neg;
    logic [31:0]        mag;
    logic [15:0]        kp;
    logic signed [31:0] esum;
    logic signed [32:0] dlt;
    logic signed [31:0] position;
    logic signed [31:0] deviation;
    logic               settled;
    status_t            next_status;
    logic               edge_error;
  } a_item_t;

  // after multiply stage
  typedef struct packed {
    logic               control;
    logic               neg;
    logic [47:0]        pterm;
    logic signed [47:0] iprod;
    logic signed [48:0] dprod;
    logic signed [31:0] position;
    logic signed [31:0] deviation;
    logic               settled;
    status_t            next_status;
    logic               edge_error;
  } m_item_t;

  typedef struct packed {
    logic [15:0]        pwm_duty;
    dir_t               drive_dir;
    logic signed [31:0] position;
    logic signed [31:0] deviation;
    logic               settled;
    status_t            next_status;
    logic               edge_error;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > SAT_HI) begin
      return 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

>>> rtl/qppc_track.sv
// Encoder decode and error tracking stage: holds position, error history,
// integral sum and settle counter. Depends on qppc_pkg.
module qppc_track import qppc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    adv,
  input  logic    valid,
  input  in_item_t item,
  input  cfg_t    cfg,
  output a_item_t stage
);

  logic signed [POS_W-1:0] pos_count, pos_count_next;
  logic [1:0]              prev_pins, prev_pins_next;
  logic signed [31:0]      prev_err, prev_err_next;
  logic signed [31:0]      err_sum, err_sum_next;
  logic [CNT_W-1:0]        band_cnt, band_cnt_next;
  logic                    gain_close_sel, gain_close_sel_next;

  logic [1:0]         pins, pin_diff;
  logic               pins_x, count_up, count_dn;
  logic signed [32:0] pos_abs;
  logic signed [33:0] err_wide;
  logic signed [31:0] err;
  logic signed [32:0] err_neg;
  logic [CNT_W-1:0]   cnt_inc;
  logic               in_band, settle, is_ctrl;
  status_t            settle_status;
  a_item_t            stage_next;

  always_comb begin
    pins     = {item.pin_a, item.pin_b};
    pin_diff = pins ^ prev_pins;
    pins_x   = item.pin_a ^ item.pin_b;
    count_up = ((pin_diff == 2'b10) && pins_x) || ((pin_diff == 2'b01) && !pins_x);
    count_dn = ((pin_diff == 2'b10) && !pins_x) || ((pin_diff == 2'b01) && pins_x);

    pos_abs  = (pos_count < 0) ? -(33'(pos_count)) : 33'(pos_count);
    err_wide = 34'(item.target_pos) - 34'(pos_abs);
    err      = sat32(36'(err_wide));
    err_neg  = -(33'(err));

    in_band = (err >= -BAND) && (err <= BAND);
    cnt_inc = band_cnt + CNT_W'(1);
    settle  = cfg.enable && in_band && (cnt_inc >= CNT_W'(SETTLE_STEPS));

    case (item.phase)
      PH_CLOSE: settle_status = ST_LEVER_CLOSE;
      PH_FEED:  settle_status = ST_FEED_START2;
      default:  settle_status = ST_WAIT_INPUT;
    endcase

    case (item.phase)
      PH_CLOSE:           gain_close_sel_next = 1'b1;
      PH_RETURN, PH_FEED: gain_close_sel_next = 1'b0;
      default:            gain_close_sel_next = gain_close_sel;
    endcase

    is_ctrl        = (item.func == FUNC_CONTROL);
    pos_count_next = pos_count;
    prev_pins_next = prev_pins;
    prev_err_next  = prev_err;
    err_sum_next   = err_sum;
    band_cnt_next  = band_cnt;
    if (!is_ctrl) begin
      prev_pins_next = pins;
      if (count_up) begin
        pos_count_next = pos_count + POS_W'(1);
      end else if (count_dn) begin
        pos_count_next = pos_count - POS_W'(1);
      end
    end else begin
      prev_err_next = err;
      err_sum_next  = sat32(36'(err_sum) + 36'(err));
      if (settle) begin
        band_cnt_next = '0;
      end else if (cfg.enable && in_band) begin
        band_cnt_next = cnt_inc;
      end
    end

    stage_next.control     = is_ctrl;
    stage_next.neg         = (err < 0);
    stage_next.mag         = (err < 0) ? err_neg[31:0] : err;
    stage_next.kp          = gain_close_sel_next ? cfg.gain_close : cfg.gain_feed;
    stage_next.esum        = err_sum_next;
    stage_next.dlt         = 33'(err) - 33'(prev_err);
    stage_next.position    = 32'(pos_count_next);
    stage_next.deviation   = prev_err_next;
    stage_next.settled     = is_ctrl && settle;
    stage_next.next_status = (is_ctrl && settle) ? settle_status : ST_NONE;
    stage_next.edge_error  = !is_ctrl && (pin_diff == 2'b11);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_count      <= '0;
      prev_pins      <= '0;
      prev_err       <= '0;
      err_sum        <= '0;
      band_cnt       <= '0;
      gain_close_sel <= 1'b0;
    end else if (adv && valid) begin
      pos_count      <= pos_count_next;
      prev_pins      <= prev_pins_next;
      prev_err       <= prev_err_next;
      err_sum        <= err_sum_next;
      band_cnt       <= band_cnt_next;
      if (is_ctrl) begin
        gain_close_sel <= gain_close_sel_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage <= stage_next;
    end
  end

endmodule

>>> rtl/qppc_mult.sv
// Multiply stage: proportional, integral and derivative products, registered.
// Depends on qppc_pkg.
module qppc_mult import qppc_pkg::*; (
  input  logic    clk,
  input  logic    adv,
  input  a_item_t a_in,
  input  cfg_t    cfg,
  output m_item_t stage
);

  m_item_t stage_next;

  always_comb begin
    stage_next.control     = a_in.control;
    stage_next.neg         = a_in.neg;
    stage_next.pterm       = 48'(a_in.kp) * 48'(a_in.mag);
    stage_next.iprod       = 48'($signed({1'b0, cfg.integral_gain})) * 48'(a_in.esum);
    stage_next.dprod       = 49'($signed({1'b0, cfg.derivative_gain})) * 49'(a_in.dlt);
    stage_next.position    = a_in.position;
    stage_next.deviation   = a_in.deviation;
    stage_next.settled     = a_in.settled;
    stage_next.next_status = a_in.next_status;
    stage_next.edge_error  = a_in.edge_error;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage <= stage_next;
    end
  end

endmodule

>>> rtl/qppc_drive.sv
// Drive stage: sums the PID terms, clamps the duty, applies the settle back-off
// and holds the applied duty and direction. Depends on qppc_pkg.
module qppc_drive import qppc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    adv,
  input  logic    valid,
  input  m_item_t m_in,
  input  cfg_t    cfg,
  output result_t res
);

  logic [15:0]             held_duty, held_duty_next;
  dir_t                    held_dir, held_dir_next;
  logic signed [47:0]      iabs;
  logic signed [31:0]      iterm_mag, iterm;
  logic signed [DRV_W-1:0] drive, dmin, dmax, back, pid_ofs;
  logic [15:0]             duty, back_duty;
  result_t                 res_next;

  always_comb begin
    iabs      = (m_in.iprod < 0) ? -m_in.iprod : m_in.iprod;
    iterm_mag = 32'(iabs >>> 16);
    iterm     = (m_in.iprod < 0) ? -iterm_mag : iterm_mag;

    dmin    = DRV_W'($signed({1'b0, cfg.drive_min}));
    dmax    = DRV_W'($signed({1'b0, cfg.drive_max}));
    pid_ofs = m_in.neg ? (DRV_W'(m_in.dprod) - DRV_W'(iterm))
                       : (DRV_W'(iterm) - DRV_W'(m_in.dprod));
    drive   = DRV_W'($signed({1'b0, m_in.pterm})) + dmin + pid_ofs;

    if (drive < dmin) begin
      duty = cfg.drive_min;
    end else if (drive > dmax) begin
      duty = cfg.drive_max;
    end else begin
      duty = drive[15:0];
    end

    back = drive - DRV_W'(SETTLE_BACKOFF);
    if (back < 0) begin
      back_duty = '0;
    end else if (back > DRV_W'(16'hFFFF)) begin
      back_duty = 16'hFFFF;
    end else begin
      back_duty = back[15:0];
    end

    held_duty_next = held_duty;
    held_dir_next  = held_dir;
    if (m_in.control) begin
      if (m_in.settled) begin
        held_duty_next = back_duty;
        held_dir_next  = DIR_BRAKE;
      end else begin
        held_duty_next = duty;
        held_dir_next  = m_in.neg ? DIR_FORWARD : DIR_REVERSE;
      end
    end

    res_next.pwm_duty    = held_duty_next;
    res_next.drive_dir   = held_dir_next;
    res_next.position    = m_in.position;
    res_next.deviation   = m_in.deviation;
    res_next.settled     = m_in.settled;
    res_next.next_status = m_in.next_status;
    res_next.edge_error  = m_in.edge_error;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_duty <= '0;
      held_dir  <= DIR_BRAKE;
    end else if (adv && valid) begin
      held_duty <= held_duty_next;
      held_dir  <= held_dir_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

endmodule

>>> rtl/quadrature_position_pid_controller.sv
// Top level of the quadrature position PID controller: ports, configuration
// registers, input register and pipeline control. Depends on qppc_pkg,
// qppc_track, qppc_mult, qppc_drive and the assertion macro header.
//
//   channel   dir  handshake              payload
//   s_*       in   s_tvalid / s_tready    s_tdata (encoder pins, target, phase), s_tuser func
//   m_*       out  m_tvalid / m_tready    m_tdata (duty, dir, position, deviation, flags)
//   cfg_*     in   cfg_we                 cfg_addr, cfg_wdata
//
// One beat per cycle sustained while m_tready keeps up; an accepted beat passes the input
// register (loaded on the accepting edge), then the tracking stage, multiply stage and
// output register before it shows on m_tvalid.
// Position and error state update in the tracking stage, so back-to-back beats
// see each other's effect. A stalled output freezes the whole pipeline and
// drops s_tready. Reset clears valids, config and tracking and drive state; it holds brake.
module quadrature_position_pid_controller import qppc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // pin_a, pin_b, target_pos[31:0], phase[1:0], pad
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // pwm_duty[15:0], drive_dir[1:0], position[31:0],
                                 // deviation[31:0], settled, next_status[1:0],
                                 // edge_error, pad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

`include "quadrature_position_pid_controller_macros.svh"

  cfg_t     cfg;
  in_item_t in_item;
  logic     in_valid, a_valid, m_valid, adv;
  a_item_t  a_stage;
  m_item_t  m_stage;
  result_t  res;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_close      <= 16'd40;
      cfg.gain_feed       <= 16'd7;
      cfg.integral_gain   <= 16'd0;
      cfg.derivative_gain <= 16'd30;
      cfg.drive_min       <= 16'd16000;
      cfg.drive_max       <= 16'd60000;
      cfg.enable          <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_GAIN_CLOSE:      cfg.gain_close      <= cfg_wdata;
        REG_GAIN_FEED:       cfg.gain_feed       <= cfg_wdata;
        REG_INTEGRAL_GAIN:   cfg.integral_gain   <= cfg_wdata;
        REG_DERIVATIVE_GAIN: cfg.derivative_gain <= cfg_wdata;
        REG_DRIVE_MIN:       cfg.drive_min       <= cfg_wdata;
        REG_DRIVE_MAX:       cfg.drive_max       <= cfg_wdata;
        REG_ENABLE:          cfg.enable          <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      a_valid  <= 1'b0;
      m_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      in_valid <= s_tvalid;
      a_valid  <= in_valid;
      m_valid  <= a_valid;
      m_tvalid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_item.func       <= func_t'(s_tuser);
      in_item.pin_a      <= s_tdata[0];
      in_item.pin_b      <= s_tdata[1];
      in_item.target_pos <= s_tdata[33:2];
      in_item.phase      <= phase_t'(s_tdata[35:34]);
    end
  end

  qppc_track u_track (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .valid (in_valid),
    .item  (in_item),
    .cfg   (cfg),
    .stage (a_stage)
  );

  qppc_mult u_mult (
    .clk   (clk),
    .adv   (adv),
    .a_in  (a_stage),
    .cfg   (cfg),
    .stage (m_stage)
  );

  qppc_drive u_drive (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .valid (m_valid),
    .m_in  (m_stage),
    .cfg   (cfg),
    .res   (res)
  );

  assign m_tdata = {2'b00, res.edge_error, res.next_status, res.settled,
                    res.deviation, res.position, res.drive_dir, res.pwm_duty};

  `QPPC_ASSERT_IMP(a_settle_brakes, m_tvalid && res.settled, res.drive_dir == DIR_BRAKE && res.next_status != ST_NONE)
  `QPPC_ASSERT_IMP(a_edge_no_settle, m_tvalid && res.edge_error, !res.settled && res.next_status == ST_NONE)
  `QPPC_ASSERT_IMP(a_stall_from_out, !s_tready, m_tvalid && !m_tready)
  `QPPC_ASSERT_NXT(a_pipe_drains, m_valid && s_tready, m_tvalid)

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// Testbench for quadrature_position_pid_controller: directed table plus random beats,
// every output beat checked against a typed expectation or an in-bench model of the decoder and PID stage.
// Depends on qppc_pkg and the controller RTL.
module tb;
  import qppc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 225;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  // up-count order of {a, b}: 00 -> 10 -> 11 -> 01
  localparam logic [7:0] GRAY_UP = {2'b01, 2'b11, 2'b10, 2'b00};

  typedef enum bit {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    in_item_t    beat;
    int          reps;
    bit          typed;
    result_t     want;
    logic [2:0]  addr;
    logic [15:0] wdata;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int stall_cycles = 0;
  int bad_beats = 0;

  result_t servo_results_due[$];
  plan_row_t plan[$];

  // model state
  cfg_t        m_cfg;
  logic [31:0] m_pos;
  logic [1:0]  m_pins;
  int          m_prev_err;
  int          m_err_sum;
  logic [4:0]  m_band;
  bit          m_close;
  logic [15:0] m_duty;
  dir_t        m_dir;

  quadrature_position_pid_controller uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int sat_int(longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return int'(v);
  endfunction

  function automatic result_t predict_servo_result(in_item_t it);
    result_t r;
    logic [1:0] pins, diff;
    longint p, absp, d, kp, mag, iterm, dterm, drive, back;
    int e;
    r = '0;
    r.next_status = ST_NONE;
    if (it.func == FUNC_ENCODER) begin
      pins = {it.pin_a, it.pin_b};
      diff = pins ^ m_pins;
      if (diff == 2'b11) begin
        r.edge_error = 1'b1;
      end else if (diff == 2'b10) begin
        m_pos = (it.pin_a ^ it.pin_b) ? m_pos + 32'd1 : m_pos - 32'd1;
      end else if (diff == 2'b01) begin
        m_pos = (it.pin_a == it.pin_b) ? m_pos + 32'd1 : m_pos - 32'd1;
      end
      m_pins = pins;
    end else begin
      p = longint'($signed(m_pos));
      absp = (p < 0) ? -p : p;
      e = sat_int(longint'(it.target_pos) - absp);
      d = longint'(e) - longint'(m_prev_err);
      if (it.phase == PH_CLOSE) begin
        m_close = 1'b1;
      end else if (it.phase != PH_OTHER) begin
        m_close = 1'b0;
      end
      kp = m_close ? longint'(m_cfg.gain_close) : longint'(m_cfg.gain_feed);
      m_err_sum = sat_int(longint'(m_err_sum) + longint'(e));
      mag = (e < 0) ? -longint'(e) : longint'(e);
      // integer division truncates toward zero
      iterm = (longint'(m_cfg.integral_gain) * longint'(m_err_sum)) / 65536;
      dterm = longint'(m_cfg.derivative_gain) * d;
      if (e >= 0) begin
        drive = kp * mag + longint'(m_cfg.drive_min) + iterm - dterm;
        m_dir = DIR_REVERSE;
      end else begin
        drive = kp * mag + longint'(m_cfg.drive_min) - iterm + dterm;
        m_dir = DIR_FORWARD;
      end
      if (drive < longint'(m_cfg.drive_min)) begin
        m_duty = m_cfg.drive_min;
      end else if (drive > longint'(m_cfg.drive_max)) begin
        m_duty = m_cfg.drive_max;
      end else begin
        m_duty = drive[15:0];
      end
      m_prev_err = e;
      if (m_cfg.enable && e >= -BAND && e <= BAND) begin
        m_band = m_band + 5'd1;
        if (m_band >= SETTLE_STEPS) begin
          back = drive - SETTLE_BACKOFF;
          if (back < 0) begin
            back = 0;
          end else if (back > 65535) begin
            back = 65535;
          end
          m_duty = back[15:0];
          m_dir = DIR_BRAKE;
          r.settled = 1'b1;
          r.next_status = (it.phase == PH_CLOSE) ? ST_LEVER_CLOSE :
                          (it.phase == PH_FEED)  ? ST_FEED_START2 : ST_WAIT_INPUT;
          m_band = '0;
        end
      end
    end
    r.pwm_duty = m_duty;
    r.drive_dir = m_dir;
    r.position = m_pos;
    r.deviation = m_prev_err;
    return r;
  endfunction

  function automatic plan_row_t mk_beat(func_t f, bit a, bit b, int tgt, phase_t ph, int reps);
    plan_row_t r;
    r.kind = ROW_BEAT;
    r.beat.func = f;
    r.beat.pin_a = a;
    r.beat.pin_b = b;
    r.beat.target_pos = tgt;
    r.beat.phase = ph;
    r.reps = reps;
    r.typed = 1'b0;
    r.want = '0;
    r.addr = '0;
    r.wdata = '0;
    return r;
  endfunction

  function automatic plan_row_t mk_typed(plan_row_t r, int duty, dir_t dir, int pos, int dev,
                                         bit edge_err);
    r.typed = 1'b1;
    r.want = '0;
    r.want.pwm_duty = duty[15:0];
    r.want.drive_dir = dir;
    r.want.position = pos;
    r.want.deviation = dev;
    r.want.next_status = ST_NONE;
    r.want.edge_error = edge_err;
    return r;
  endfunction

  function automatic plan_row_t mk_reg(logic [2:0] addr, logic [15:0] val);
    plan_row_t r;
    r = mk_beat(FUNC_ENCODER, 1'b0, 1'b0, 0, PH_RETURN, 0);
    r.kind = ROW_REG;
    r.addr = addr;
    r.wdata = val;
    return r;
  endfunction

  task automatic send_beat(in_item_t it, bit typed, result_t want);
    result_t guess;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.func;
    s_tdata <= {4'b0, it.phase, it.target_pos, it.pin_b, it.pin_a};
    do @(posedge clk); while (!s_tready);
    guess = predict_servo_result(it);
    servo_results_due.push_back(typed ? want : guess);
  endtask

  task automatic wait_drained();
    while (servo_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    case (addr)
      REG_GAIN_CLOSE:      m_cfg.gain_close = val;
      REG_GAIN_FEED:       m_cfg.gain_feed = val;
      REG_INTEGRAL_GAIN:   m_cfg.integral_gain = val;
      REG_DERIVATIVE_GAIN: m_cfg.derivative_gain = val;
      REG_DRIVE_MIN:       m_cfg.drive_min = val;
      REG_DRIVE_MAX:       m_cfg.drive_max = val;
      REG_ENABLE:          m_cfg.enable = val[0];
      default: ;
    endcase
  endtask

  task automatic program_regs(cfg_t c);
    write_reg(REG_GAIN_CLOSE, c.gain_close);
    write_reg(REG_GAIN_FEED, c.gain_feed);
    write_reg(REG_INTEGRAL_GAIN, c.integral_gain);
    write_reg(REG_DERIVATIVE_GAIN, c.derivative_gain);
    write_reg(REG_DRIVE_MIN, c.drive_min);
    write_reg(REG_DRIVE_MAX, c.drive_max);
    write_reg(REG_ENABLE, {15'($urandom), c.enable});
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic check_servo_beat(logic [87:0] raw);
    result_t got, want;
    got.pwm_duty = raw[15:0];
    got.drive_dir = dir_t'(raw[17:16]);
    got.position = raw[49:18];
    got.deviation = raw[81:50];
    got.settled = raw[82];
    got.next_status = status_t'(raw[84:83]);
    got.edge_error = raw[85];
    if (servo_results_due.size() == 0) begin
      if (bad_beats < 10) $display("unexpected output beat at %0t", $time);
      bad_beats++;
    end else begin
      want = servo_results_due.pop_front();
      if (got.pwm_duty !== want.pwm_duty || got.drive_dir !== want.drive_dir ||
          got.position !== want.position || got.deviation !== want.deviation ||
          got.settled !== want.settled || got.next_status !== want.next_status ||
          got.edge_error !== want.edge_error) begin
        if (bad_beats < 10) begin
          $display("mismatch at %0t", $time);
          $display("  exp duty=%0d dir=%0d pos=%0d dev=%0d settled=%0b status=%0d edge=%0b",
                   want.pwm_duty, want.drive_dir, want.position, want.deviation,
                   want.settled, want.next_status, want.edge_error);
          $display("  got duty=%0d dir=%0d pos=%0d dev=%0d settled=%0b status=%0d edge=%0b",
                   got.pwm_duty, got.drive_dir, got.position, got.deviation,
                   got.settled, got.next_status, got.edge_error);
        end
        bad_beats++;
      end
    end
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // output checker and watchdog
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (m_tvalid && m_tready) check_servo_beat(m_tdata);
    end
  end

  initial begin
    in_item_t it;
    cfg_t c;
    int ph, n, k, g, pick, abs_pos;
    bit walk_up;
    logic [1:0] pins;

    m_cfg.gain_close = 16'd40;
    m_cfg.gain_feed = 16'd7;
    m_cfg.integral_gain = 16'd0;
    m_cfg.derivative_gain = 16'd30;
    m_cfg.drive_min = 16'd16000;
    m_cfg.drive_max = 16'd60000;
    m_cfg.enable = 1'b0;
    m_pos = '0;
    m_pins = '0;
    m_prev_err = 0;
    m_err_sum = 0;
    m_band = '0;
    m_close = 1'b0;
    m_duty = '0;
    m_dir = DIR_BRAKE;

    // directed table
    plan.push_back(mk_typed(mk_beat(FUNC_ENCODER, 0, 0, 0, PH_RETURN, 1),
                            0, DIR_BRAKE, 0, 0, 0));
    plan.push_back(mk_typed(mk_beat(FUNC_ENCODER, 1, 0, 0, PH_OTHER, 1),
                            0, DIR_BRAKE, 1, 0, 0));
    plan.push_back(mk_typed(mk_beat(FUNC_ENCODER, 1, 1, -1, PH_CLOSE, 1),
                            0, DIR_BRAKE, 2, 0, 0));
    // both pins flip: flagged, no count
    plan.push_back(mk_typed(mk_beat(FUNC_ENCODER, 0, 0, 0, PH_FEED, 1),
                            0, DIR_BRAKE, 2, 0, 1));
    plan.push_back(mk_beat(FUNC_ENCODER, 0, 1, 0, PH_RETURN, 1));
    plan.push_back(mk_beat(FUNC_CONTROL, 0, 0, 0, PH_OTHER, 1));
    plan.push_back(mk_typed(mk_beat(FUNC_CONTROL, 1, 1, 32'h7FFF_FFFF, PH_CLOSE, 1),
                            60000, DIR_REVERSE, 1, 32'h7FFF_FFFE, 0));
    plan.push_back(mk_typed(mk_beat(FUNC_CONTROL, 0, 1, 32'h8000_0000, PH_FEED, 1),
                            16000, DIR_FORWARD, 1, 32'h8000_0000, 0));
    plan.push_back(mk_beat(FUNC_CONTROL, 1, 0, -5, PH_RETURN, 1));
    plan.push_back(mk_reg(REG_ENABLE, 16'h0001));
    plan.push_back(mk_reg(REG_INTEGRAL_GAIN, 16'hFFFF));
    // twenty in-band steps, settles on the last
    plan.push_back(mk_beat(FUNC_CONTROL, 0, 0, 1, PH_FEED, 20));
    plan.push_back(mk_reg(REG_DRIVE_MIN, 16'd50000));
    plan.push_back(mk_reg(REG_DRIVE_MAX, 16'd1000));
    plan.push_back(mk_reg(REG_UNUSED, 16'hFFFF));
    plan.push_back(mk_beat(FUNC_CONTROL, 0, 0, 100, PH_CLOSE, 1));
    plan.push_back(mk_beat(FUNC_CONTROL, 0, 0, -100, PH_OTHER, 1));
    plan.push_back(mk_reg(REG_GAIN_CLOSE, 16'hFFFF));
    plan.push_back(mk_reg(REG_GAIN_FEED, 16'h0000));
    plan.push_back(mk_reg(REG_DERIVATIVE_GAIN, 16'hFFFF));
    plan.push_back(mk_beat(FUNC_CONTROL, 1, 1, 41, PH_CLOSE, 1));
    plan.push_back(mk_beat(FUNC_CONTROL, 1, 1, -39, PH_RETURN, 1));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        s_tvalid <= 1'b0;
        wait_drained();
        write_reg(plan[i].addr, plan[i].wdata);
      end else begin
        cfg_we <= 1'b0;
        repeat (plan[i].reps) send_beat(plan[i].beat, plan[i].typed, plan[i].want);
      end
    end

    for (ph = 0; ph < 8; ph++) begin
      s_tvalid <= 1'b0;
      wait_drained();
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 74; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 74; end
        default: begin src_idle_pct = 12; sink_stall_pct = 12; end
      endcase
      c.gain_close = 16'($urandom);
      c.gain_feed = 16'($urandom);
      c.integral_gain = 16'($urandom);
      c.derivative_gain = 16'($urandom);
      c.drive_min = 16'($urandom);
      c.drive_max = 16'($urandom);
      c.enable = 1'b1;
      case (ph)
        0: begin
          c.gain_close = 16'd40; c.gain_feed = 16'd7; c.integral_gain = 16'd0;
          c.derivative_gain = 16'd30; c.drive_min = 16'd16000; c.drive_max = 16'd60000;
        end
        1: begin
          c = '1;
        end
        2: begin
          c = '0;
        end
        4: begin
          c.drive_min = 16'($urandom_range(65535, 40000));
          c.drive_max = 16'($urandom_range(20000));
        end
        5: begin
          c.gain_close = 16'($urandom_range(60)); c.gain_feed = 16'($urandom_range(60));
          c.derivative_gain = 16'd0; c.drive_min = 16'd1000; c.drive_max = 16'd65535;
        end
        6: c.enable = 1'($urandom);
        7: begin
          c.gain_close = 16'd40; c.gain_feed = 16'd7; c.derivative_gain = 16'd30;
          c.drive_min = 16'd16000; c.drive_max = 16'd60000;
        end
        default: ;
      endcase
      program_regs(c);
      walk_up = 1'($urandom);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) begin
          s_tvalid <= 1'b0;
          wait_drained();
        end
        if ($urandom_range(49) == 0) walk_up = !walk_up;
        it.target_pos = 32'($urandom);
        it.phase = phase_t'($urandom_range(3));
        pins = m_pins;
        pick = $urandom_range(99);
        if (pick < 45) begin
          g = 0;
          for (k = 0; k < 4; k++) begin
            if (GRAY_UP[2*k +: 2] == m_pins) g = k;
          end
          g = walk_up ? (g + 1) % 4 : (g + 3) % 4;
          pins = GRAY_UP[2*g +: 2];
          it.func = FUNC_ENCODER;
        end else if (pick < 50) begin
          if ($urandom_range(1)) pins = m_pins ^ 2'b11;
          it.func = FUNC_ENCODER;
        end else begin
          it.func = FUNC_CONTROL;
          abs_pos = ($signed(m_pos) < 0) ? -$signed(m_pos) : $signed(m_pos);
          pick = $urandom_range(99);
          if (pick < 80) begin
            it.target_pos = abs_pos + $urandom_range(120) - 60;
          end else if (pick >= 90) begin
            case ($urandom_range(3))
              0: it.target_pos = 32'h7FFF_FFFF;
              1: it.target_pos = 32'h8000_0000;
              2: it.target_pos = 0;
              default: it.target_pos = -1;
            endcase
          end
          if ($urandom_range(3) != 0) pins = 2'($urandom);
        end
        it.pin_a = pins[1];
        it.pin_b = pins[0];
        send_beat(it, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (bad_beats == 0 && servo_results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> quadrature_position_pid_controller.f
+incdir+rtl
rtl/qppc_pkg.sv
rtl/qppc_track.sv
rtl/qppc_mult.sv
rtl/qppc_drive.sv
rtl/quadrature_position_pid_controller.sv
verif/tb.sv
